/* design/mrra_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mrra_pkg;

	localparam int BATCH_W     = 8;
	localparam int POS_W       = 12;
	localparam int REG_W       = 13;
	localparam int ADDR_W      = 32;
	localparam int IN_W        = BATCH_W + 2 * POS_W;
	localparam int CFG_IDX_W   = 3;
	localparam int RADIX_SLOTS = 3;
	localparam int MAX_RADICES = 3;

	// restoring divider: quotient bits per stage, stages per division
	localparam int DIV_STEPS      = 4;
	localparam int STAGES_PER_DIV = POS_W / DIV_STEPS;
	localparam int SPLIT_STAGES   = RADIX_SLOTS * STAGES_PER_DIV;

	localparam int PROD1_W = POS_W + REG_W;
	localparam int T1_W    = PROD1_W + 1;
	localparam int PROD2_W = T1_W + REG_W;
	localparam int BR_W    = BATCH_W + REG_W;
	localparam int BRC_W   = BR_W + REG_W;
	localparam int PROD3_W = ADDR_W + REG_W;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_RADIX_0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X_RADIX_1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_X_RADIX_2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_RADIX_0 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_Y_RADIX_1 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_Y_RADIX_2 = 3'd7;

	typedef logic [RADIX_SLOTS-1:0][REG_W-1:0] radix_vec_t;
	typedef logic [RADIX_SLOTS-1:0][POS_W-1:0] digit_vec_t;

	typedef struct packed {
		logic [REG_W-1:0] row_count;
		logic [REG_W-1:0] col_count;
		radix_vec_t       x_radix;
		radix_vec_t       y_radix;
	} radix_cfg_t;

	typedef struct packed {
		logic [REG_W-1:0] rem;
		logic [POS_W-1:0] num;
		digit_vec_t       dig;
	} lane_t;

	typedef struct packed {
		logic [BATCH_W-1:0] batch;
		logic               err;
		lane_t              x;
		lane_t              y;
	} split_t;

	typedef struct packed {
		logic [BATCH_W-1:0] batch;
		logic               err;
		digit_vec_t         x_dig;
		digit_vec_t         y_dig;
	} digits_t;

	// zero radix acts as one, slots past the radix limit are fixed at one
	function automatic logic [REG_W-1:0] eff_radix(input logic [REG_W-1:0] value,
			input int slot);
		return (slot < MAX_RADICES && value != '0) ? value : REG_W'(1);
	endfunction

	function automatic lane_t div_steps(input lane_t lane_in, input logic [REG_W-1:0] divisor);
		lane_t          l;
		logic [REG_W:0] trial;
		logic [REG_W:0] diff;
		logic           ge;
		l = lane_in;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {l.rem, l.num[POS_W-1]};
			diff  = trial - {1'b0, divisor};
			ge    = (trial >= {1'b0, divisor});
			l.rem = ge ? diff[REG_W-1:0] : trial[REG_W-1:0];
			l.num = {l.num[POS_W-2:0], ge};
		end
		return l;
	endfunction

endpackage

`default_nettype wire

/* design/mrra_digit_split.sv */
`timescale 1ns / 1ps
`default_nettype none

module mrra_digit_split (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [mrra_pkg::BATCH_W-1:0] in_batch,
	input  wire logic [mrra_pkg::POS_W-1:0]   in_row,
	input  wire logic [mrra_pkg::POS_W-1:0]   in_col,
	input  wire mrra_pkg::radix_cfg_t         cfg,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output mrra_pkg::digits_t                 out
);

	localparam int NS  = mrra_pkg::SPLIT_STAGES;
	localparam int SPD = mrra_pkg::STAGES_PER_DIV;
	localparam int PW  = mrra_pkg::POS_W;

	mrra_pkg::split_t split_s [NS];
	logic             valid_s [NS];
	logic [NS:0]      en;

	assign en[NS]   = out_ready;
	assign in_ready = en[0];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int J = k / SPD;
		mrra_pkg::split_t cur;
		mrra_pkg::split_t nxt;
		logic             vin;

		if (k == 0) begin : g_head
			always_comb begin
				cur       = '0;
				cur.batch = in_batch;
				cur.err   = ({1'b0, in_row} >= cfg.row_count) ||
				            ({1'b0, in_col} >= cfg.col_count);
				cur.x.num = in_row;
				cur.y.num = in_col;
			end
			assign vin = in_valid;
		end else if ((k % SPD) == 0) begin : g_next_digit
			// remainder of the previous division is a digit, its quotient goes on
			always_comb begin
				cur            = split_s[k-1];
				cur.x.dig[J-1] = split_s[k-1].x.rem[PW-1:0];
				cur.y.dig[J-1] = split_s[k-1].y.rem[PW-1:0];
				cur.x.rem      = '0;
				cur.y.rem      = '0;
			end
			assign vin = valid_s[k-1];
		end else begin : g_body
			assign cur = split_s[k-1];
			assign vin = valid_s[k-1];
		end

		always_comb begin
			nxt   = cur;
			nxt.x = mrra_pkg::div_steps(cur.x, cfg.x_radix[J]);
			nxt.y = mrra_pkg::div_steps(cur.y, cfg.y_radix[J]);
		end

		assign en[k] = ~valid_s[k] | en[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en[k]) begin
				valid_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				split_s[k] <= nxt;
			end
		end
	end

	assign out_valid = valid_s[NS-1];

	always_comb begin
		out.batch = split_s[NS-1].batch;
		out.err   = split_s[NS-1].err;
		out.x_dig = split_s[NS-1].x.dig;
		out.y_dig = split_s[NS-1].y.dig;
		out.x_dig[mrra_pkg::RADIX_SLOTS-1] = split_s[NS-1].x.rem[PW-1:0];
		out.y_dig[mrra_pkg::RADIX_SLOTS-1] = split_s[NS-1].y.rem[PW-1:0];
	end

endmodule

`default_nettype wire

/* design/mrra_addr_calc.sv */
`timescale 1ns / 1ps
`default_nettype none

module mrra_addr_calc (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire mrra_pkg::digits_t           in,
	input  wire mrra_pkg::radix_cfg_t        cfg,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [mrra_pkg::ADDR_W-1:0]      source_index,
	output logic                             range_error
);

	localparam int AW = mrra_pkg::ADDR_W;
	localparam int PW = mrra_pkg::POS_W;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	logic [mrra_pkg::T1_W-1:0] tx_s1, ty_s1;
	logic [mrra_pkg::BR_W-1:0] br_s1;
	logic [PW-1:0]             dx2_s1, dy2_s1;
	logic                      err_s1;

	logic [AW-1:0] revx_s2, revy_s2, brc_s2;
	logic          err_s2;

	logic [AW-1:0] a_s3, b_s3;
	logic          err_s3;

	logic [AW-1:0] idx_s4;
	logic          err_s4;

	logic [mrra_pkg::PROD1_W-1:0] px1, py1;
	logic [mrra_pkg::PROD2_W-1:0] px2, py2;
	logic [mrra_pkg::BRC_W-1:0]   pbrc;
	logic [mrra_pkg::PROD3_W-1:0] prx;

	assign en4      = ~valid_s4 | out_ready;
	assign en3      = ~valid_s3 | en4;
	assign en2      = ~valid_s2 | en3;
	assign en1      = ~valid_s1 | en2;
	assign in_ready = en1;

	// first level of the digit recombination: d0*r1 + d1
	assign px1 = in.x_dig[0] * cfg.x_radix[1];
	assign py1 = in.y_dig[0] * cfg.y_radix[1];
	// second level: (..)*r2 + d2, kept modulo 2^32
	assign px2 = tx_s1 * cfg.x_radix[2];
	assign py2 = ty_s1 * cfg.y_radix[2];
	assign pbrc = br_s1 * cfg.col_count;
	assign prx  = revx_s2 * cfg.col_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			tx_s1  <= mrra_pkg::T1_W'(px1) + mrra_pkg::T1_W'(in.x_dig[1]);
			ty_s1  <= mrra_pkg::T1_W'(py1) + mrra_pkg::T1_W'(in.y_dig[1]);
			br_s1  <= in.batch * cfg.row_count;
			dx2_s1 <= in.x_dig[2];
			dy2_s1 <= in.y_dig[2];
			err_s1 <= in.err;
		end
		if (en2) begin
			revx_s2 <= px2[AW-1:0] + AW'(dx2_s1);
			revy_s2 <= py2[AW-1:0] + AW'(dy2_s1);
			brc_s2  <= pbrc[AW-1:0];
			err_s2  <= err_s1;
		end
		if (en3) begin
			a_s3   <= prx[AW-1:0];
			b_s3   <= brc_s2 + revy_s2;
			err_s3 <= err_s2;
		end
		if (en4) begin
			idx_s4 <= err_s3 ? '0 : a_s3 + b_s3;
			err_s4 <= err_s3;
		end
	end

	assign out_valid    = valid_s4;
	assign source_index = idx_s4;
	assign range_error  = err_s4;

endmodule

`default_nettype wire

/* design/mixed_radix_reorder_address_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// throughput: one beat per cycle unless the output is held, set by nine restoring-divider stages
// (4 quotient bits each, three digits per coordinate) followed by four multiply/add stages
// each stage advances on its own, so bubbles close up while the output is held
// reset: arst_n clears all valid bits at once and sets every config register to 1

module mixed_radix_reorder_address_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// batch_index, row_position, col_position
	input  wire logic [mrra_pkg::IN_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// source_index
	output logic [mrra_pkg::ADDR_W-1:0]         m_axis_tdata,
	// range_error
	output logic                                m_axis_tuser,
	input  wire logic                           cfg_wr_en,
	input  wire logic [mrra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mrra_pkg::REG_W-1:0]     cfg_data
);

	localparam int BW = mrra_pkg::BATCH_W;
	localparam int PW = mrra_pkg::POS_W;
	localparam int RW = mrra_pkg::REG_W;

	logic [RW-1:0]        row_count_q;
	logic [RW-1:0]        col_count_q;
	mrra_pkg::radix_vec_t x_radix_q;
	mrra_pkg::radix_vec_t y_radix_q;
	mrra_pkg::radix_cfg_t cfg;

	logic              mid_valid;
	logic              mid_ready;
	mrra_pkg::digits_t mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= RW'(1);
			col_count_q <= RW'(1);
			for (int i = 0; i < mrra_pkg::RADIX_SLOTS; i++) begin
				x_radix_q[i] <= RW'(1);
				y_radix_q[i] <= RW'(1);
			end
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mrra_pkg::REG_ROW_COUNT: row_count_q  <= cfg_data;
				mrra_pkg::REG_COL_COUNT: col_count_q  <= cfg_data;
				mrra_pkg::REG_X_RADIX_0: x_radix_q[0] <= cfg_data;
				mrra_pkg::REG_X_RADIX_1: x_radix_q[1] <= cfg_data;
				mrra_pkg::REG_X_RADIX_2: x_radix_q[2] <= cfg_data;
				mrra_pkg::REG_Y_RADIX_0: y_radix_q[0] <= cfg_data;
				mrra_pkg::REG_Y_RADIX_1: y_radix_q[1] <= cfg_data;
				mrra_pkg::REG_Y_RADIX_2: y_radix_q[2] <= cfg_data;
			endcase
		end
	end

	always_comb begin
		cfg.row_count = row_count_q;
		cfg.col_count = col_count_q;
		for (int i = 0; i < mrra_pkg::RADIX_SLOTS; i++) begin
			cfg.x_radix[i] = mrra_pkg::eff_radix(x_radix_q[i], i);
			cfg.y_radix[i] = mrra_pkg::eff_radix(y_radix_q[i], i);
		end
	end

	mrra_digit_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_batch  (s_axis_tdata[BW-1:0]),
		.in_row    (s_axis_tdata[BW+PW-1:BW]),
		.in_col    (s_axis_tdata[BW+2*PW-1:BW+PW]),
		.cfg       (cfg),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out       (mid)
	);

	mrra_addr_calc u_calc (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (mid_valid),
		.in_ready     (mid_ready),
		.in           (mid),
		.cfg          (cfg),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.source_index (m_axis_tdata),
		.range_error  (m_axis_tuser)
	);

endmodule

`default_nettype wire

/* design/mrra_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module mrra_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_axis_tvalid,
	input wire logic                       s_axis_tready,
	input wire logic                       m_axis_tvalid,
	input wire logic                       m_axis_tready,
	input wire logic [mrra_pkg::ADDR_W-1:0] m_axis_tdata,
	input wire logic                       m_axis_tuser
);

	// beats accepted on the slave side and not yet taken on the master side
	logic [4:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 5'(s_axis_tvalid && s_axis_tready)
				- 5'(m_axis_tvalid && m_axis_tready);
		end
	end

	// an out-of-range position always yields address zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("range_error beat with nonzero source_index");

	// the input side only backs up when the whole pipe is full and the output is held
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("slave side stalled without output backpressure");

	// a master beat only comes from an earlier slave beat
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != '0)
		else $error("master beat without a pending slave beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("master beat changed while stalled");

endmodule

bind mixed_radix_reorder_address_top mrra_checker u_checker (.*);

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [mrra_pkg::ADDR_W-1:0] source_index;
		logic                        range_error;
	} addr_result_t;

	// mirror of the address generator: register copy, digit reversal and expected beats
	class reorder_addr_board;
		logic [mrra_pkg::REG_W-1:0] rows;
		logic [mrra_pkg::REG_W-1:0] cols;
		mrra_pkg::radix_vec_t       x_radix;
		mrra_pkg::radix_vec_t       y_radix;
		addr_result_t               expected_addrs[$];
		int                         mismatches;

		function new();
			rows        = 1;
			cols        = 1;
			x_radix     = {mrra_pkg::RADIX_SLOTS{mrra_pkg::REG_W'(1)}};
			y_radix     = {mrra_pkg::RADIX_SLOTS{mrra_pkg::REG_W'(1)}};
			mismatches  = 0;
		endfunction

		function void set_register(logic [mrra_pkg::CFG_IDX_W-1:0] idx,
				logic [mrra_pkg::REG_W-1:0] value);
			case (idx)
				mrra_pkg::REG_ROW_COUNT: rows = value;
				mrra_pkg::REG_COL_COUNT: cols = value;
				mrra_pkg::REG_X_RADIX_0: x_radix[0] = value;
				mrra_pkg::REG_X_RADIX_1: x_radix[1] = value;
				mrra_pkg::REG_X_RADIX_2: x_radix[2] = value;
				mrra_pkg::REG_Y_RADIX_0: y_radix[0] = value;
				mrra_pkg::REG_Y_RADIX_1: y_radix[1] = value;
				mrra_pkg::REG_Y_RADIX_2: y_radix[2] = value;
				default: ;
			endcase
		endfunction

		// split into digits, least significant first, then rebuild in reversed order
		function logic [63:0] reverse_digits(logic [mrra_pkg::POS_W-1:0] pos,
				mrra_pkg::radix_vec_t radix);
			logic [63:0] rest;
			logic [63:0] base;
			logic [63:0] rev;
			logic [63:0] digit[3];
			rest = pos;
			for (int i = 0; i < 3; i++) begin
				base = (radix[i] == '0) ? 64'd1 : 64'(radix[i]);
				digit[i] = rest % base;
				rest = rest / base;
			end
			rev = 0;
			for (int i = 0; i < 3; i++) begin
				base = (radix[i] == '0) ? 64'd1 : 64'(radix[i]);
				rev = rev * base + digit[i];
			end
			return rev;
		endfunction

		function void note_position(logic [mrra_pkg::BATCH_W-1:0] batch,
				logic [mrra_pkg::POS_W-1:0] row, logic [mrra_pkg::POS_W-1:0] col);
			addr_result_t want;
			logic [63:0]  addr;
			if (64'(row) >= 64'(rows) || 64'(col) >= 64'(cols)) begin
				want.source_index = '0;
				want.range_error  = 1'b1;
			end else begin
				addr = 64'(batch) * 64'(rows) * 64'(cols)
					+ reverse_digits(row, x_radix) * 64'(cols)
					+ reverse_digits(col, y_radix);
				want.source_index = addr[mrra_pkg::ADDR_W-1:0];
				want.range_error  = 1'b0;
			end
			expected_addrs.push_back(want);
		endfunction

		function void check_address(logic [mrra_pkg::ADDR_W-1:0] idx, logic err);
			addr_result_t want;
			if (expected_addrs.size() == 0) begin
				mismatches++;
				$display("%0t unexpected beat: expected none, actual %h / %b", $time, idx, err);
				return;
			end
			want = expected_addrs.pop_front();
			if (idx !== want.source_index) begin
				mismatches++;
				$display("%0t source_index: expected %h actual %h", $time,
					want.source_index, idx);
			end
			if (err !== want.range_error) begin
				mismatches++;
				$display("%0t range_error: expected %b actual %b", $time,
					want.range_error, err);
			end
		endfunction

		function int pending_count();
			return expected_addrs.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [mrra_pkg::IN_W-1:0]      s_axis_tdata = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [mrra_pkg::ADDR_W-1:0]    m_axis_tdata;
	logic                           m_axis_tuser;
	logic                           cfg_wr_en = 1'b0;
	logic [mrra_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mrra_pkg::REG_W-1:0]     cfg_data = '0;

	// receiver control; rx_style and hold_req are written by the main sequence
	logic [1:0] rx_style = 2'd0;
	logic       hold_req = 1'b0;
	logic       hold_seen;
	int         hold_left;
	int         stall_tick;

	// sender burst shaping
	int burst_max = 1;
	int gap_max = 0;
	int burst_left = 1;

	reorder_addr_board board;

	mixed_radix_reorder_address_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// receiver stall pattern; a toggle of hold_req starts a long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_seen     <= 1'b0;
			hold_left     <= 0;
			stall_tick    <= 0;
		end else begin
			stall_tick <= stall_tick + 1;
			if (hold_req != hold_seen) begin
				hold_seen     <= hold_req;
				hold_left     <= 300;
				m_axis_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left     <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				case (rx_style)
					2'd0: m_axis_tready <= 1'b1;
					2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ((stall_tick % 7) < 4);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_address(m_axis_tdata, m_axis_tuser);
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_position(input logic [mrra_pkg::BATCH_W-1:0] batch,
			input logic [mrra_pkg::POS_W-1:0] row, input logic [mrra_pkg::POS_W-1:0] col);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {col, row, batch};
		do @(posedge clk); while (!s_axis_tready);
		board.note_position(batch, row, col);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, burst_max);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending_count() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mrra_pkg::CFG_IDX_W-1:0] idx,
			input logic [mrra_pkg::REG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		board.set_register(idx, value);
	endtask

	task automatic apply_setup(input mrra_pkg::radix_cfg_t s);
		write_reg(mrra_pkg::REG_ROW_COUNT, s.row_count);
		write_reg(mrra_pkg::REG_COL_COUNT, s.col_count);
		write_reg(mrra_pkg::REG_X_RADIX_0, s.x_radix[0]);
		write_reg(mrra_pkg::REG_X_RADIX_1, s.x_radix[1]);
		write_reg(mrra_pkg::REG_X_RADIX_2, s.x_radix[2]);
		write_reg(mrra_pkg::REG_Y_RADIX_0, s.y_radix[0]);
		write_reg(mrra_pkg::REG_Y_RADIX_1, s.y_radix[1]);
		write_reg(mrra_pkg::REG_Y_RADIX_2, s.y_radix[2]);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [mrra_pkg::REG_W-1:0] pick_radix();
		case ($urandom_range(0, 3))
			0: return mrra_pkg::REG_W'(1);
			1: return mrra_pkg::REG_W'($urandom_range(2, 8));
			2: return mrra_pkg::REG_W'($urandom_range(2, 16));
			default: return mrra_pkg::REG_W'(16);
		endcase
	endfunction

	// mostly consistent counts; otherwise odd radices, zero radices and counts off the product
	function automatic mrra_pkg::radix_cfg_t random_setup();
		mrra_pkg::radix_cfg_t s;
		logic [31:0]          x_prod;
		logic [31:0]          y_prod;
		int                   slot;
		x_prod = 1;
		y_prod = 1;
		for (int i = 0; i < 3; i++) begin
			s.x_radix[i] = pick_radix();
			s.y_radix[i] = pick_radix();
			x_prod = x_prod * s.x_radix[i];
			y_prod = y_prod * s.y_radix[i];
		end
		s.row_count = mrra_pkg::REG_W'(x_prod);
		s.col_count = mrra_pkg::REG_W'(y_prod);
		if ($urandom_range(0, 3) == 0) begin
			slot = $urandom_range(0, 2);
			s.x_radix[slot] = $urandom_range(0, 1) ? '0 :
				mrra_pkg::REG_W'($urandom_range(0, 8191));
			slot = $urandom_range(0, 2);
			s.y_radix[slot] = $urandom_range(0, 1) ? '0 :
				mrra_pkg::REG_W'($urandom_range(0, 8191));
			s.row_count = $urandom_range(0, 1) ? mrra_pkg::REG_W'(x_prod + 1) :
				mrra_pkg::REG_W'($urandom_range(1, 8191));
			s.col_count = $urandom_range(0, 1) ? mrra_pkg::REG_W'(y_prod - 1) :
				mrra_pkg::REG_W'($urandom_range(1, 8191));
		end
		return s;
	endfunction

	task automatic send_random_position(input mrra_pkg::radix_cfg_t s);
		int          row_lim;
		int          col_lim;
		logic [11:0] row;
		logic [11:0] col;
		row_lim = (s.row_count > 4096) ? 4096 : int'(s.row_count);
		col_lim = (s.col_count > 4096) ? 4096 : int'(s.col_count);
		row = (row_lim == 0 || $urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095)) :
			12'($urandom_range(0, row_lim - 1));
		col = (col_lim == 0 || $urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095)) :
			12'($urandom_range(0, col_lim - 1));
		send_position(8'($urandom_range(0, 255)), row, col);
	endtask

	initial begin
		mrra_pkg::radix_cfg_t s;
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: one row, one column
		rx_style <= 2'd1;
		gap_max   = 2;
		burst_max = 3;
		send_position(8'd0, 12'd0, 12'd0);
		send_position(8'd255, 12'd0, 12'd0);
		send_position(8'd3, 12'd1, 12'd0);
		send_position(8'd3, 12'd0, 12'd1);
		wait_drained();

		s.row_count = 13'd24;
		s.x_radix   = {13'd3, 13'd2, 13'd4};
		s.col_count = 13'd40;
		s.y_radix   = {13'd5, 13'd1, 13'd8};
		apply_setup(s);
		send_position(8'd0, 12'd0, 12'd0);
		send_position(8'd255, 12'd23, 12'd39);
		send_position(8'd17, 12'd5, 12'd11);
		send_position(8'd3, 12'd24, 12'd0);
		send_position(8'd3, 12'd0, 12'd40);
		send_position(8'd3, 12'd4095, 12'd4095);
		wait_drained();

		// largest legal sizes, one radix at its maximum
		s.row_count = 13'd4096;
		s.x_radix   = {13'd16, 13'd16, 13'd16};
		s.col_count = 13'd4096;
		s.y_radix   = {13'd1, 13'd4096, 13'd1};
		apply_setup(s);
		send_position(8'd255, 12'd4095, 12'd4095);
		send_position(8'd128, 12'd2048, 12'd1);
		send_position(8'd0, 12'd1, 12'd4095);
		wait_drained();

		// zero radices, counts off the product, address wraps past 32 bits
		s.row_count = 13'd8191;
		s.x_radix   = {13'd7, 13'd8191, 13'd0};
		s.col_count = 13'd8191;
		s.y_radix   = {13'd8191, 13'd0, 13'd3};
		apply_setup(s);
		send_position(8'd255, 12'd4095, 12'd4095);
		send_position(8'd85, 12'd2730, 12'd1365);
		send_position(8'd170, 12'd1365, 12'd2730);
		send_position(8'd1, 12'd0, 12'd0);
		wait_drained();

		// zero row count rejects everything
		s.row_count = 13'd0;
		s.col_count = 13'd5;
		apply_setup(s);
		send_position(8'd0, 12'd0, 12'd0);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			s = random_setup();
			apply_setup(s);
			rx_style <= 2'(ph % 4);
			gap_max   = (ph % 3 == 0) ? 0 : (ph % 3 == 1 ? 3 : 12);
			burst_max = (ph % 2 == 0) ? 20 : 4;
			if (ph == 2) begin
				// long receiver hold-off with the sender streaming back to back
				gap_max  = 0;
				hold_req <= ~hold_req;
			end
			for (int n = 0; n < 150; n++) begin
				if (ph == 5 && n == 75) begin
					s_axis_tvalid <= 1'b0;
					while (board.pending_count() != 0) @(posedge clk);
				end
				send_random_position(s);
			end
			wait_drained();
		end

		if (board.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/mrra_pkg.sv
design/mrra_digit_split.sv
design/mrra_addr_calc.sv
design/mixed_radix_reorder_address_top.sv
design/mrra_checker.sv
tb/sv/tb.sv
